// ----- hw/rtl/hzr_pkg.sv -----
package hzr_pkg;

    // Fixed field widths of the item and result words
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 12;
    localparam int CHILD_W  = 13;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 10;
    localparam int REG_W    = 13;
    localparam int BIT_W    = 5;

    localparam logic [BIT_W-1:0] LAST_BIT = 5'(WORD_W - 1);

    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 80;

    // Item kinds carried on the input tuser
    localparam logic [ACTION_W-1:0] ACT_LOAD_NODE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SYM  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STREAM    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_NODE_BASE = 1'b0;
    localparam logic CFG_TREE_SIZE = 1'b1;

    typedef struct packed {
        logic               node_we;
        logic               sym_we;
        logic [INDEX_W-1:0] index;
        logic [CHILD_W-1:0] child_one;
        logic [CHILD_W-1:0] child_zero;
        logic [WORD_W-1:0]  symbol;
    } t_load_req;

endpackage

// ----- hw/rtl/hzr_tree_store.sv -----
module hzr_tree_store #(
    parameter int NODE_DEPTH   = 4096,
    parameter int SYMBOL_DEPTH = 4096,
    parameter int CHILD_BITS   = 13
) (
    input  logic                      i_clk,
    input  hzr_pkg::t_load_req        i_load,
    input  logic [hzr_pkg::REG_W-1:0] i_node_addr,
    input  logic                      i_sym_rd,
    input  logic [hzr_pkg::REG_W-1:0] i_sym_addr,
    output logic [2*CHILD_BITS-1:0]   o_kids,
    output logic [hzr_pkg::WORD_W-1:0] o_sym
);
    import hzr_pkg::*;

    localparam int NODE_AW = $clog2(NODE_DEPTH);
    localparam int SYM_AW  = $clog2(SYMBOL_DEPTH);

    logic [2*CHILD_BITS-1:0] r_node_mem [NODE_DEPTH];
    logic [WORD_W-1:0]       r_sym_mem  [SYMBOL_DEPTH];

    logic [2*CHILD_BITS-1:0] r_kids;
    logic                    r_node_oob;
    logic [WORD_W-1:0]       r_sym;
    logic                    r_sym_oob;

    // Node store: write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_load.node_we && (32'(i_load.index) < NODE_DEPTH)) begin
            r_node_mem[NODE_AW'(i_load.index)] <=
                {CHILD_BITS'(i_load.child_one), CHILD_BITS'(i_load.child_zero)};
        end
        r_kids     <= r_node_mem[NODE_AW'(i_node_addr)];
        r_node_oob <= (32'(i_node_addr) >= NODE_DEPTH);
    end

    // Symbol table: write on load, read on request only so the word holds
    always_ff @(posedge i_clk) begin
        if (i_load.sym_we && (32'(i_load.index) < SYMBOL_DEPTH)) begin
            r_sym_mem[SYM_AW'(i_load.index)] <= i_load.symbol;
        end
        if (i_sym_rd) begin
            r_sym     <= r_sym_mem[SYM_AW'(i_sym_addr)];
            r_sym_oob <= (32'(i_sym_addr) >= SYMBOL_DEPTH);
        end
    end

    // Out-of-range entries read as zero
    assign o_kids = r_node_oob ? '0 : r_kids;
    assign o_sym  = r_sym_oob  ? '0 : r_sym;

endmodule

// ----- hw/rtl/huffman_zero_run_decoder.sv -----
// Channel   | Dir | Word contents
// ----------+-----+----------------------------------------------------------
// s_axis    | in  | tuser: action; tlast: last_word; tdata: entry_index,
//           |     |   child_one, child_zero, symbol_word, stream_word
// m_axis    | out | tlast: last_of_word; tdata: value_out, repeat_count,
//           |     |   emitted_total
// i_cfg     | in  | index 0 node_base, index 1 tree size (13 bits)
//
// A stream word is walked one coded bit per cycle unless stalled, through the
// node memory (read every cycle at the next node), with a symbol read step per
// leaf and a closing step. Each result is held back one step so the last one of
// a word can carry tlast. The walk stalls in place while the held result must
// move into a full output register; tready rises only when idle.
// Reset is synchronous and clears control state; the memories are not cleared.
module huffman_zero_run_decoder #(
    parameter int NODE_DEPTH   = 4096,
    parameter int SYMBOL_DEPTH = 4096,
    parameter int RUN_W        = 10,
    parameter int CHILD_BITS   = 13
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // fields from bit 0: entry_index, child_one, child_zero, symbol_word,
    // stream_word, zero fill
    input  logic [hzr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // fields from bit 0: action
    input  logic [hzr_pkg::ACTION_W-1:0]     s_axis_tuser,
    input  logic                             s_axis_tlast,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // fields from bit 0: value_out, repeat_count, emitted_total, zero fill
    output logic [hzr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_wen,
    input  logic                             i_cfg_idx,
    input  logic [hzr_pkg::REG_W-1:0]        i_cfg_wdata
);
    import hzr_pkg::*;

    localparam int BL_W = $clog2(RUN_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_SYM  = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    // Unpacked input fields
    logic [INDEX_W-1:0] in_index;
    logic [CHILD_W-1:0] in_child_one;
    logic [CHILD_W-1:0] in_child_zero;
    logic [WORD_W-1:0]  in_symbol;
    logic [WORD_W-1:0]  in_stream;

    assign in_index      = s_axis_tdata[11:0];
    assign in_child_one  = s_axis_tdata[24:12];
    assign in_child_zero = s_axis_tdata[37:25];
    assign in_symbol     = s_axis_tdata[69:38];
    assign in_stream     = s_axis_tdata[101:70];

    // Control and walk state
    logic [1:0]          r_state,      n_state;
    logic [REG_W-1:0]    r_node_base,  n_node_base;
    logic [REG_W-1:0]    r_tree_size,  n_tree_size;
    logic [REG_W-1:0]    r_node,       n_node;
    logic [RUN_W-1:0]    r_gather,     n_gather;
    logic [BL_W-1:0]     r_left,       n_left;
    logic [WORD_W-1:0]   r_tally,      n_tally;
    logic [WORD_W-1:0]   r_word,       n_word;
    logic [BIT_W-1:0]    r_bit,        n_bit;
    logic                r_last,       n_last;
    logic                r_sym_last,   n_sym_last;

    // Held-back result and output register
    logic                r_pend_v,     n_pend_v;
    logic [WORD_W-1:0]   r_pend_value, n_pend_value;
    logic [COUNT_W-1:0]  r_pend_count, n_pend_count;
    logic [WORD_W-1:0]   r_pend_total, n_pend_total;
    logic                r_ov,         n_ov;
    logic [WORD_W-1:0]   r_out_value,  n_out_value;
    logic [COUNT_W-1:0]  r_out_count,  n_out_count;
    logic [WORD_W-1:0]   r_out_total,  n_out_total;
    logic                r_out_last,   n_out_last;

    // Store interface
    t_load_req                load_req;
    logic [2*CHILD_BITS-1:0]  kids;
    logic [WORD_W-1:0]        sym_data;
    logic                     sym_rd;
    logic [REG_W-1:0]         sym_addr;

    // Per-cycle walk terms
    logic [REG_W-1:0]    root;
    logic                accept;
    logic                out_free;
    logic                have_new;
    logic                proceed;
    logic [WORD_W-1:0]   new_value;
    logic [RUN_W-1:0]    new_count;
    logic [RUN_W-1:0]    gath;
    logic [CHILD_W-1:0]  child;

    assign root          = r_tree_size - REG_W'(1);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;

    always_comb begin
        load_req            = '0;
        load_req.node_we    = accept && (s_axis_tuser == ACT_LOAD_NODE);
        load_req.sym_we     = accept && (s_axis_tuser == ACT_LOAD_SYM);
        load_req.index      = in_index;
        load_req.child_one  = in_child_one;
        load_req.child_zero = in_child_zero;
        load_req.symbol     = in_symbol;
    end

    // Bit 1 takes the first child, bit 0 the second
    assign child = r_word[0] ? CHILD_W'(kids[2*CHILD_BITS-1:CHILD_BITS])
                             : CHILD_W'(kids[CHILD_BITS-1:0]);

    // Run length gathers LSB first: shift in from the top, once per length bit
    assign gath = RUN_W'({r_word[0], r_gather} >> 1);

    always_comb begin
        have_new  = 1'b0;
        new_value = '0;
        new_count = '0;
        case (r_state)
            ST_WALK: begin
                if (r_left != '0) begin
                    have_new  = (r_left == BL_W'(1)) && (gath != '0);
                    new_count = gath;
                end
            end
            ST_SYM: begin
                have_new  = 1'b1;
                new_value = sym_data;
                new_count = RUN_W'(1);
            end
            default: begin
                have_new = 1'b0;
            end
        endcase
    end

    // A new result may only displace the held one into a free output slot
    assign proceed = !have_new || !r_pend_v || out_free;

    always_comb begin
        n_state      = r_state;
        n_node_base  = r_node_base;
        n_tree_size  = r_tree_size;
        n_node       = r_node;
        n_gather     = r_gather;
        n_left       = r_left;
        n_tally      = r_tally;
        n_word       = r_word;
        n_bit        = r_bit;
        n_last       = r_last;
        n_sym_last   = r_sym_last;
        n_pend_v     = r_pend_v;
        n_pend_value = r_pend_value;
        n_pend_count = r_pend_count;
        n_pend_total = r_pend_total;
        n_ov         = r_ov;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        n_out_total  = r_out_total;
        n_out_last   = r_out_last;
        sym_rd       = 1'b0;
        sym_addr     = child;

        if (r_ov && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept && (s_axis_tuser == ACT_STREAM)) begin
                    n_word  = in_stream;
                    n_bit   = '0;
                    n_last  = s_axis_tlast;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (proceed) begin
                    n_word = r_word >> 1;
                    n_bit  = r_bit + BIT_W'(1);
                    n_state = (r_bit == LAST_BIT) ? ST_END : ST_WALK;
                    if (r_left != '0) begin
                        n_left   = r_left - BL_W'(1);
                        n_gather = (r_left == BL_W'(1)) ? '0 : gath;
                    end else if (child >= r_node_base) begin
                        n_node = child - r_node_base;
                    end else begin
                        n_node = root;
                        if (child == '0) begin
                            // run marker: gather the length next
                            n_left   = BL_W'(RUN_W);
                            n_gather = '0;
                        end else begin
                            sym_rd     = 1'b1;
                            n_sym_last = (r_bit == LAST_BIT);
                            n_state    = ST_SYM;
                        end
                    end
                end
            end
            ST_SYM: begin
                if (proceed) begin
                    n_state = r_sym_last ? ST_END : ST_WALK;
                end
            end
            default: begin
                // close the word: flush the held result with tlast set
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        n_ov        = 1'b1;
                        n_out_value = r_pend_value;
                        n_out_count = r_pend_count;
                        n_out_total = r_pend_total;
                        n_out_last  = 1'b1;
                        n_pend_v    = 1'b0;
                    end
                    if (r_last) begin
                        n_node   = root;
                        n_gather = '0;
                        n_left   = '0;
                        n_tally  = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
        endcase

        if (have_new && proceed) begin
            if (r_pend_v) begin
                n_ov        = 1'b1;
                n_out_value = r_pend_value;
                n_out_count = r_pend_count;
                n_out_total = r_pend_total;
                n_out_last  = 1'b0;
            end
            n_tally      = r_tally + WORD_W'(new_count);
            n_pend_v     = 1'b1;
            n_pend_value = new_value;
            n_pend_count = COUNT_W'(new_count);
            n_pend_total = r_tally + WORD_W'(new_count);
        end

        // Register writes must arrive only while idle; the block does not enforce it.
        if (i_cfg_wen) begin
            if (i_cfg_idx == CFG_NODE_BASE) begin
                n_node_base = i_cfg_wdata;
            end else begin
                n_tree_size = i_cfg_wdata;
                n_node      = i_cfg_wdata - REG_W'(1);
                n_gather    = '0;
                n_left      = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_base  <= '0;
            r_tree_size  <= REG_W'(1);
            r_node       <= '0;
            r_gather     <= '0;
            r_left       <= '0;
            r_tally      <= '0;
            r_pend_v     <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_base  <= n_node_base;
            r_tree_size  <= n_tree_size;
            r_node       <= n_node;
            r_gather     <= n_gather;
            r_left       <= n_left;
            r_tally      <= n_tally;
            r_pend_v     <= n_pend_v;
            r_ov         <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_last       <= n_last;
        r_sym_last   <= n_sym_last;
        r_pend_value <= n_pend_value;
        r_pend_count <= n_pend_count;
        r_pend_total <= n_pend_total;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
        r_out_total  <= n_out_total;
        r_out_last   <= n_out_last;
    end

    // Node memory is read every cycle at the next node, so its data always
    // matches r_node; a stalled cycle rereads the same entry.
    hzr_tree_store #(
        .NODE_DEPTH   (NODE_DEPTH),
        .SYMBOL_DEPTH (SYMBOL_DEPTH),
        .CHILD_BITS   (CHILD_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_load      (load_req),
        .i_node_addr (n_node),
        .i_sym_rd    (sym_rd),
        .i_sym_addr  (sym_addr),
        .o_kids      (kids),
        .o_sym       (sym_data)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {6'b0, r_out_total, r_out_count, r_out_value};

    // No held result may remain once the block takes new words
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_pend_v)
        else $error("held result left over while idle");

    // Symbol reads never happen while a run length is being gathered
    a_sym_not_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SYM) |-> (r_left == '0))
        else $error("symbol fetch during run length");

    // Displacing a held result puts it on the output without tlast
    a_push_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (have_new && proceed && r_pend_v) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("displaced result not presented");

    // Closing a final word restarts the walk at the root with a zero tally
    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_END && n_state == ST_IDLE && r_last && !i_cfg_wen)
        |=> (r_tally == '0 && r_node == $past(root)))
        else $error("stream end did not restart the walk");

endmodule

// ----- tb/sv/huffman_zero_run_decoder_test.sv -----
module huffman_zero_run_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hzr_pkg::*;

    localparam int NODE_SLOTS    = 4096;
    localparam int SYMBOL_SLOTS  = 4096;
    localparam int RUN_LEN_BITS  = 10;
    localparam int RESET_CYCLES  = 11;
    // Time for a coded word to finish inside the block; give it some margin
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TREE_SETUPS   = 7;
    localparam int CODED_PER_SETUP = 40;

    // Action code the block does not use; it must swallow such a word silently
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // Output tdata field positions, lowest first
    localparam int VALUE_LO = 0;
    localparam int COUNT_LO = VALUE_LO + WORD_W;
    localparam int TOTAL_LO = COUNT_LO + COUNT_W;

    typedef struct {
        bit [WORD_W-1:0]  value;
        bit [COUNT_W-1:0] count;
        bit [WORD_W-1:0]  total;
        bit               last;
    } t_decoded_value;

    // Tracks the decoder's own state and the values it must put out, in order
    class decode_scoreboard;
        bit [2*CHILD_W-1:0] node_mem [NODE_SLOTS];
        bit [WORD_W-1:0]    symbol_mem [SYMBOL_SLOTS];
        bit [REG_W-1:0]     node_base;
        bit [REG_W-1:0]     tree_size;
        bit [CHILD_W-1:0]   walk_node;
        bit [COUNT_W-1:0]   run_gather;
        bit [3:0]           run_left;
        bit [WORD_W-1:0]    value_tally;
        t_decoded_value     expected_values[$];
        int unsigned        mismatches;
        int unsigned        checked;

        function new();
            tree_size = 13'd1;
            restart_walk();
        endfunction

        function void restart_walk();
            walk_node  = tree_size - 13'd1;
            run_gather = '0;
            run_left   = '0;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        function void write_reg(logic idx, bit [REG_W-1:0] value);
            if (idx == CFG_NODE_BASE) begin
                node_base = value;
            end else begin
                tree_size = value;
                restart_walk();
            end
        endfunction

        function t_decoded_value tally_value(bit [WORD_W-1:0] value, bit [COUNT_W-1:0] count);
            t_decoded_value v;
            value_tally += WORD_W'(count);
            v.value = value;
            v.count = count;
            v.total = value_tally;
            v.last  = 1'b0;
            return v;
        endfunction

        // Apply one accepted input word and queue the values it yields
        function void note_word(bit [ACTION_W-1:0] act, bit [INDEX_W-1:0] idx,
                                bit [CHILD_W-1:0] c1, bit [CHILD_W-1:0] c0,
                                bit [WORD_W-1:0] sym, bit [WORD_W-1:0] coded, bit fin);
            t_decoded_value     fresh[$];
            bit [2*CHILD_W-1:0] kids;
            bit [CHILD_W-1:0]   child;
            bit                 b;
            int                 i;
            case (act)
                ACT_LOAD_NODE: node_mem[idx] = {c1, c0};
                ACT_LOAD_SYM:  symbol_mem[idx] = sym;
                ACT_STREAM: begin
                    for (i = 0; i < WORD_W; i++) begin
                        b = coded[i];
                        if (run_left != 0) begin
                            run_gather[4'(RUN_LEN_BITS) - run_left] = b;
                            run_left--;
                            if (run_left == 0) begin
                                if (run_gather != 0)
                                    fresh.push_back(tally_value('0, run_gather));
                                run_gather = '0;
                            end
                        end else begin
                            kids  = (walk_node < 13'(NODE_SLOTS)) ? node_mem[walk_node[11:0]]
                                                                    : '0;
                            child = b ? kids[2*CHILD_W-1:CHILD_W] : kids[CHILD_W-1:0];
                            if (child >= node_base) begin
                                walk_node = child - node_base;
                            end else begin
                                walk_node = tree_size - 13'd1;
                                if (child == 0) begin
                                    run_left   = 4'(RUN_LEN_BITS);
                                    run_gather = '0;
                                end else begin
                                    fresh.push_back(tally_value(
                                        (child < 13'(SYMBOL_SLOTS)) ? symbol_mem[child[11:0]]
                                                                    : '0, 10'd1));
                                end
                            end
                        end
                    end
                    if (fresh.size() > 0)
                        fresh[fresh.size() - 1].last = 1'b1;
                    foreach (fresh[k])
                        expected_values.push_back(fresh[k]);
                    if (fin) begin
                        restart_walk();
                        value_tally = '0;
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_value(bit [WORD_W-1:0] value, bit [COUNT_W-1:0] count,
                         bit [WORD_W-1:0] total, bit last);
            t_decoded_value want;
            checked++;
            if (expected_values.size() == 0) begin
                report($sformatf("value %h count %0d total %0d with nothing pending",
                                 value, count, total));
                return;
            end
            want = expected_values.pop_front();
            if (value != want.value)
                report($sformatf("value %h, want %h", value, want.value));
            if (count != want.count)
                report($sformatf("repeat count %0d, want %0d", count, want.count));
            if (total != want.total)
                report($sformatf("emitted total %0d, want %0d", total, want.total));
            if (last != want.last)
                report($sformatf("last of word %0b, want %0b", last, want.last));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [ACTION_W-1:0]    s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_wen     = 1'b0;
    logic                   i_cfg_idx     = CFG_NODE_BASE;
    logic [REG_W-1:0]       i_cfg_wdata   = '0;

    decode_scoreboard board = new();

    // Knobs shared between the sender, the receiver and the sequence
    bit               sender_gaps;
    bit               quiet_tail;
    bit               hold_request;
    int               phase_base;
    int               phase_nodes;
    bit [CHILD_W-1:0] leaf_pool[$];
    int unsigned      words_sent;
    int unsigned      coded_sent;

    huffman_zero_run_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one word, optionally after a random idle burst, and hold it until
    // the block takes it. tvalid stays high on return so back-to-back words
    // need only one assignment per edge.
    task automatic drive_word(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                              logic [CHILD_W-1:0] c1, logic [CHILD_W-1:0] c0,
                              logic [WORD_W-1:0] sym, logic [WORD_W-1:0] coded, logic fin);
        int gap;
        gap = 0;
        if (!quiet_tail && sender_gaps && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // tdata from bit 0: entry_index, child_one, child_zero, symbol_word,
        // stream_word, zero fill
        s_axis_tdata  <= IN_TDATA_W'({coded, sym, c0, c1, idx});
        s_axis_tuser  <= act;
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.note_word(act, idx, c1, c0, sym, coded, fin);
        words_sent++;
        if (act == ACT_STREAM)
            coded_sent++;
    endtask

    // Unused fields carry random bits so that every field bit of tdata toggles
    task automatic load_node(logic [INDEX_W-1:0] idx, logic [CHILD_W-1:0] c1,
                             logic [CHILD_W-1:0] c0);
        drive_word(ACT_LOAD_NODE, idx, c1, c0, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic load_symbol(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] value);
        drive_word(ACT_LOAD_SYM, idx, 13'($urandom), 13'($urandom), value, $urandom,
                   1'($urandom));
    endtask

    task automatic stream_word(logic [WORD_W-1:0] coded, logic fin);
        drive_word(ACT_STREAM, 12'($urandom), 13'($urandom), 13'($urandom), $urandom,
                   coded, fin);
    endtask

    // Drop tvalid, wait out every pending value, then give the block time to
    // finish a word that produced nothing.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write node_base, then the tree size; the size write also resets the walk
    task automatic write_regs(logic [REG_W-1:0] base, logic [REG_W-1:0] count);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= CFG_NODE_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        board.write_reg(CFG_NODE_BASE, base);
        i_cfg_idx   <= CFG_TREE_SIZE;
        i_cfg_wdata <= count;
        @(posedge i_clk);
        board.write_reg(CFG_TREE_SIZE, count);
        i_cfg_wen   <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] symbol_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll == 2) return 32'h8000_0000;
        return $urandom;
    endfunction

    // Children only ever point at nodes of the current tree, at the run marker or
    // at pooled leaves, so a walk driven by any bit pattern never reads an empty node entry.
    function automatic logic [CHILD_W-1:0] pick_child();
        int roll;
        roll = $urandom_range(0, 99);
        if (phase_base == 0 || roll < 30)
            return 13'(phase_base + $urandom_range(0, phase_nodes - 1));
        if (roll < 45)
            return '0;  // run marker
        return leaf_pool[$urandom_range(0, leaf_pool.size() - 1)];
    endfunction

    // Load a fresh random tree: leaves first, then every node of the tree
    task automatic set_up_tree(int base, int nodes);
        int               top;
        int               j;
        bit [CHILD_W-1:0] leaf;
        drain();
        write_regs(13'(base), 13'(nodes));
        phase_base  = base;
        phase_nodes = nodes;
        leaf_pool.delete();
        repeat ($urandom_range(3, 6)) begin
            top = base - 1;
            // Above the symbol table leaves read as zero; keep most of them inside
            if (top > SYMBOL_SLOTS - 1 && $urandom_range(0, 3) != 0)
                top = SYMBOL_SLOTS - 1;
            leaf = 13'($urandom_range(1, top));
            leaf_pool.push_back(leaf);
            if (leaf < 13'(SYMBOL_SLOTS))
                load_symbol(leaf[INDEX_W-1:0], symbol_value());
        end
        for (j = 0; j < nodes; j++)
            load_node(12'(j), pick_child(), pick_child());
    endtask

    // Receiver: check every accepted word, stall in random bursts, and once
    // hold off for a long stretch so the block backs up into its input
    initial begin
        int hold_left;
        int stall_left;
        bit stall_mode;
        hold_left  = 0;
        stall_left = 0;
        stall_mode = 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                board.check_value(m_axis_tdata[VALUE_LO +: WORD_W],
                                  m_axis_tdata[COUNT_LO +: COUNT_W],
                                  m_axis_tdata[TOTAL_LO +: WORD_W], m_axis_tlast);
            if ($urandom_range(0, 199) == 0)
                stall_mode = !stall_mode;
            if (hold_left > 0) begin
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!quiet_tail && stall_mode && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            m_axis_tready <= (hold_left == 0 && stall_left == 0);
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles, %0d values pending",
                 WATCHDOG_LIMIT, board.pending());
        $display("huffman_zero_run_decoder_test failed");
        $finish;
    end

    initial begin
        int phase;
        int roll;
        bit [CHILD_W-1:0] leaf;
        sender_gaps = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Widest settings: every child below 8191 is a leaf, node 4095 is the root,
        // child 8191 leads to node 0, and leaf 8190 lies past the symbol table
        write_regs(13'h1FFF, 13'd4096);
        load_symbol(12'hFFF, 32'hFFFF_FFFF);
        load_node(12'hFFF, 13'h1FFF, 13'd0);
        load_node(12'd0, 13'd4095, 13'd8190);
        stream_word(32'h0000_07FE, 1'b0);  // run marker then ten ones: longest run
        stream_word(32'hFFFF_FFFF, 1'b0);  // end the split run, then fifteen symbol codes
        stream_word(32'h0000_0000, 1'b0);  // leaf 8190 reads zero, then zero-length runs
        stream_word(32'hFFFF_FFFF, 1'b0);  // finish a run split across words
        stream_word(32'h5555_5555, 1'b1);  // sixteen codes to leaf 8190, then end of stream
        stream_word(32'hFFFF_FFFF, 1'b1);  // tally restarts after end of stream
        drive_word(ACT_UNUSED, 12'($urandom), 13'($urandom), 13'($urandom), $urandom,
                   $urandom, 1'($urandom));

        // Node 1 jumps to node 4999, past the node store, whose children read zero
        drain();
        write_regs(13'd1, 13'd2);
        load_node(12'd1, 13'd5000, 13'd1);
        load_node(12'd0, 13'd0, 13'd2);
        stream_word($urandom, 1'b0);
        stream_word($urandom, 1'b0);
        stream_word($urandom, 1'b1);

        // No leaves at all: the walk spins through nodes and never yields a value
        drain();
        write_regs(13'd0, 13'd1);
        load_node(12'd0, 13'd0, 13'd6000);
        stream_word($urandom, 1'b0);

        // Random trees with random coded words, plus some noise in between
        for (phase = 0; phase < TREE_SETUPS; phase++) begin
            if (phase == TREE_SETUPS - 1)
                quiet_tail = 1'b1;
            sender_gaps = ($urandom_range(0, 2) != 0);
            set_up_tree((phase == 3) ? $urandom_range(4100, 8180) : $urandom_range(2, 64),
                        $urandom_range(2, 10));
            if (phase == 1)
                hold_request = 1'b1;
            repeat (CODED_PER_SETUP) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    drive_word(ACT_UNUSED, 12'($urandom), 13'($urandom), 13'($urandom),
                               $urandom, $urandom, 1'($urandom));
                end else if (roll < 8) begin
                    load_node(12'($urandom_range(0, phase_nodes - 1)), pick_child(),
                              pick_child());
                end else if (roll < 10) begin
                    leaf = leaf_pool[$urandom_range(0, leaf_pool.size() - 1)];
                    if (leaf < 13'(SYMBOL_SLOTS))
                        load_symbol(leaf[INDEX_W-1:0], symbol_value());
                end else begin
                    stream_word($urandom, $urandom_range(0, 9) == 0);
                end
            end
        end

        drain();
        $display("sent %0d words (%0d coded) over %0d tree setups plus directed cases",
                 words_sent, coded_sent, TREE_SETUPS);
        $display("checked %0d decoded values, %0d mismatches", board.checked,
                 board.mismatches);
        if (board.mismatches == 0)
            $display("huffman_zero_run_decoder_test passed");
        else
            $display("huffman_zero_run_decoder_test failed");
        $finish;
    end

endmodule

// ----- huffman_zero_run_decoder.f -----
hw/rtl/hzr_pkg.sv
hw/rtl/hzr_tree_store.sv
hw/rtl/huffman_zero_run_decoder.sv
tb/sv/huffman_zero_run_decoder_test.sv
